// ===== rtl/core/cse_pkg.sv =====
package cse_pkg;

    // Field widths
    localparam int X_W      = 16;
    localparam int COEF_W   = 16;
    localparam int DEG_W    = 3;
    localparam int IDX_W    = 3;
    localparam int Y_W      = 19;

    // Degree limit of the polynomial table, default for the top level
    localparam int DEG_LIMIT       = 5;
    localparam int MAX_DEGREE_DEF  = 5;
    localparam int NUM_COEF        = DEG_LIMIT + 1;

    // Internal widths: powers in Q.30, products, T values, weighted terms
    localparam int FRAC_X   = 15;
    localparam int FRAC_P   = 30;
    localparam int POW_W    = 32;
    localparam int PROD_W   = POW_W + X_W;
    localparam int T_W      = 37;
    localparam int TERM_W   = T_W + COEF_W;
    localparam int ACC_W    = 56;

    localparam logic signed [POW_W-1:0]  POW_ONE  = POW_W'(1) << FRAC_P;
    localparam logic signed [PROD_W-1:0] P_RND    = PROD_W'(1) << (FRAC_X - 1);
    localparam logic signed [ACC_W-1:0]  ACC_RND  = ACC_W'(1) << (FRAC_P - 1);
    localparam logic signed [ACC_W-1:0]  Y_HI     = ACC_W'((1 << (Y_W - 1)) - 1);
    localparam logic signed [ACC_W-1:0]  Y_LO     = -Y_HI - ACC_W'(1);

    // Configuration register indexes
    typedef enum logic [IDX_W-1:0] {
        CFG_DEGREE,
        CFG_COEF0,
        CFG_COEF1,
        CFG_COEF2,
        CFG_COEF3,
        CFG_COEF4,
        CFG_COEF5
    } t_cfg_index;

    // Powers p0..p5 of x in Q.30
    typedef logic [NUM_COEF-1:0][POW_W-1:0] t_pow_vec;

    // Data handed from cell to cell
    typedef struct packed {
        logic                     last;
        logic signed [X_W-1:0]    x;
        t_pow_vec                 pw;
        logic signed [ACC_W-1:0]  acc;
    } t_cell_data;

    // T_k as integer combination of p0..p5 (row k, column j)
    localparam int CHEB_C [0:DEG_LIMIT][0:DEG_LIMIT] = '{
        '{ 1,  0,  0,   0, 0,  0},
        '{ 0,  1,  0,   0, 0,  0},
        '{-1,  0,  2,   0, 0,  0},
        '{ 0, -3,  0,   4, 0,  0},
        '{ 1,  0, -8,   0, 8,  0},
        '{ 0,  5,  0, -20, 0, 16}
    };

    // T_k in Q.30 from the powers; k is a constant at each call site
    function automatic logic signed [T_W-1:0] cheb_term(input int k, input t_pow_vec pw);
        logic signed [T_W-1:0] sum;
        sum = '0;
        for (int j = 0; j <= DEG_LIMIT; j++) begin
            sum = sum + T_W'(CHEB_C[k][j]) * T_W'(signed'(pw[j]));
        end
        return sum;
    endfunction

endpackage

// ===== rtl/core/cse_cell.sv =====
module cse_cell
    import cse_pkg::*;
#(
    parameter int K = 1
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  t_cell_data               i_data,
    input  logic signed [COEF_W-1:0] i_coef,
    input  logic [DEG_W-1:0]         i_degree,
    output logic                     o_valid,
    input  logic                     i_ready,
    output t_cell_data               o_data
);

    // Stages: power multiply, round, T_k, coefficient multiply, accumulate
    localparam int NS = 5;
    localparam logic [DEG_W-1:0] K_CODE = DEG_W'(K);

    logic [NS-1:0]              r_v;
    logic [NS-1:0]              w_adv;
    t_cell_data                 r_d [NS];
    logic signed [PROD_W-1:0]   r_prod;
    logic signed [T_W-1:0]      r_t;
    logic signed [TERM_W-1:0]   r_term;
    logic signed [PROD_W-1:0]   w_round;
    t_cell_data                 n_d1;
    t_cell_data                 n_d4;

    // Stage advance: a stage moves when empty or when the next one moves
    always_comb begin
        w_adv[NS-1] = !r_v[NS-1] || i_ready;
        for (int s = NS - 2; s >= 0; s--) begin
            w_adv[s] = !r_v[s] || w_adv[s+1];
        end
    end

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_adv[0]) begin
                r_v[0] <= i_valid;
            end
            for (int s = 1; s < NS; s++) begin
                if (w_adv[s]) begin
                    r_v[s] <= r_v[s-1];
                end
            end
        end
    end

    // Round to Q.30 and insert p_K
    always_comb begin
        w_round = r_prod + P_RND;
        n_d1 = r_d[0];
        n_d1.pw[K] = w_round[FRAC_X +: POW_W];
    end

    // Add the weighted term when K is within the degree
    always_comb begin
        n_d4 = r_d[3];
        if (K_CODE <= i_degree) begin
            n_d4.acc = r_d[3].acc + ACC_W'(r_term);
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (w_adv[0]) begin
            r_d[0] <= i_data;
            r_prod <= signed'(i_data.pw[K-1]) * i_data.x;
        end
        if (w_adv[1]) begin
            r_d[1] <= n_d1;
        end
        if (w_adv[2]) begin
            r_d[2] <= r_d[1];
            r_t    <= cheb_term(K, r_d[1].pw);
        end
        if (w_adv[3]) begin
            r_d[3] <= r_d[2];
            r_term <= r_t * i_coef;
        end
        if (w_adv[4]) begin
            r_d[4] <= n_d4;
        end
    end

    assign o_ready = w_adv[0];
    assign o_valid = r_v[NS-1];
    assign o_data  = r_d[NS-1];

    // Upstream is held back only when every stage is occupied
    a_full_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> &r_v)
        else $error("cell blocked with a free stage");

    // A transaction taken in lands in the first stage
    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> r_v[0])
        else $error("accepted transaction lost in first stage");

    // A stalled result keeps its sum
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[NS-1] && !i_ready) |=> (r_v[NS-1] && $stable(r_d[NS-1].acc)))
        else $error("stalled cell output changed");

endmodule

// ===== rtl/core/chebyshev_series_eval.sv =====
// Each result passes through five register stages per cell plus the output register.
// Throughput: one sample per cycle while the output is not stalled; stages advance
// on their own, so bubbles close up and input is taken while a result waits downstream
// as long as some stage is still free.
// Reset (synchronous, active low) clears all valid bits, the degree and coefficients.
module chebyshev_series_eval
    import cse_pkg::*;
#(
    parameter int MAX_DEGREE = MAX_DEGREE_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // input samples
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic signed [X_W-1:0]    i_x_value,
    input  logic                     i_last_in,
    // results
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic signed [Y_W-1:0]    o_y_value,
    output logic                     o_last_out,
    // configuration writes
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [IDX_W-1:0]         i_cfg_index,
    input  logic [COEF_W-1:0]        i_cfg_data
);

    logic [DEG_W-1:0]           r_degree;
    logic signed [COEF_W-1:0]   r_coef [NUM_COEF];
    logic [DEG_W-1:0]           w_deg_eff;

    t_cell_data                 w_link [MAX_DEGREE+1];
    logic [MAX_DEGREE:0]        w_lv;
    logic [MAX_DEGREE:0]        w_lr;

    logic                       r_out_valid;
    logic signed [Y_W-1:0]      r_y;
    logic                       r_last;
    logic                       w_out_adv;
    logic signed [ACC_W-1:0]    w_sum;
    logic signed [ACC_W-1:0]    w_q;
    logic signed [Y_W-1:0]      n_y;

    // Configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_degree <= '0;
            for (int i = 0; i < NUM_COEF; i++) begin
                r_coef[i] <= '0;
            end
        end else if (i_cfg_valid) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_DEGREE: r_degree  <= i_cfg_data[DEG_W-1:0];
                CFG_COEF0:  r_coef[0] <= i_cfg_data;
                CFG_COEF1:  r_coef[1] <= i_cfg_data;
                CFG_COEF2:  r_coef[2] <= i_cfg_data;
                CFG_COEF3:  r_coef[3] <= i_cfg_data;
                CFG_COEF4:  r_coef[4] <= i_cfg_data;
                CFG_COEF5:  r_coef[5] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Degree above the built limit saturates
    assign w_deg_eff = (r_degree > DEG_W'(MAX_DEGREE)) ? DEG_W'(MAX_DEGREE) : r_degree;

    // Head of the chain: p0 = 1.0, sum starts with coef0 * T0
    always_comb begin
        w_link[0]       = '0;
        w_link[0].last  = i_last_in;
        w_link[0].x     = i_x_value;
        w_link[0].pw[0] = POW_ONE;
        w_link[0].acc   = ACC_W'(r_coef[0]) <<< FRAC_P;
    end
    assign w_lv[0]    = i_in_valid;
    assign o_in_ready = w_lr[0];

    // Row of cells, one per Chebyshev term
    for (genvar k = 1; k <= MAX_DEGREE; k++) begin : g_cell
        cse_cell #(
            .K (k)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_valid  (w_lv[k-1]),
            .o_ready  (w_lr[k-1]),
            .i_data   (w_link[k-1]),
            .i_coef   (r_coef[k]),
            .i_degree (w_deg_eff),
            .o_valid  (w_lv[k]),
            .i_ready  (w_lr[k]),
            .o_data   (w_link[k])
        );
    end

    // Output rounding to Q.12 and saturation
    always_comb begin
        w_sum = w_link[MAX_DEGREE].acc + ACC_RND;
        w_q   = w_sum >>> FRAC_P;
        if (w_q > Y_HI) begin
            n_y = Y_HI[Y_W-1:0];
        end else if (w_q < Y_LO) begin
            n_y = Y_LO[Y_W-1:0];
        end else begin
            n_y = w_q[Y_W-1:0];
        end
    end

    assign w_out_adv         = !r_out_valid || i_out_ready;
    assign w_lr[MAX_DEGREE]  = w_out_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_adv) begin
            r_out_valid <= w_lv[MAX_DEGREE];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_adv) begin
            r_y    <= n_y;
            r_last <= w_link[MAX_DEGREE].last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_y_value   = r_y;
    assign o_last_out  = r_last;

    // An empty output register lets the whole chain move
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> o_in_ready)
        else $error("input blocked with empty output register");

    // Output register empties when it moves with nothing behind it
    a_bubble_passes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_adv && !w_lv[MAX_DEGREE]) |=> !o_out_valid)
        else $error("result appeared from an empty slot");

    // No result right after reset
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule
